/* design/mhh_pkg.sv */
// Shared types, constants and the arctangent table of the heading unit.
`timescale 1ns / 1ps

package mhh_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CENTER_W  = 17;
    localparam int OFFSET_W  = 18;
    localparam int VEC_W     = 29;
    localparam int ANG_W     = 27;
    localparam int ZPOS_W    = 26;
    localparam int ATAN_W    = 22;
    localparam int HEADING_W = 15;
    localparam int TABLE_LEN = 24;
    localparam int TBL_IDX_W = 5;
    localparam int STATUS_W  = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam int DEF_ANGLE_STEPS       = 16;
    localparam int DEF_HEADING_FRAC_BITS = 6;

    localparam logic [ANG_W-1:0] ANG_HALF_TURN = ANG_W'(180 * 65536);
    localparam logic [ANG_W-1:0] ANG_FULL_TURN = ANG_W'(360 * 65536);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_PREP,
        S_ITER,
        S_WRAP,
        S_RESULT
    } t_state;

    typedef logic [TBL_IDX_W-1:0] t_step;

    typedef struct packed {
        logic  load;
        logic  center;
        logic  prep;
        logic  iter;
        logic  wrap;
        logic  result;
        t_step step;
    } t_dp_cmd;

    function automatic logic [ATAN_W-1:0] atan_entry(input t_step idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/mhh_ctrl.sv */
// Sequencing state machine and output valid of the heading unit.
`timescale 1ns / 1ps

module mhh_ctrl #(
    parameter int ANGLE_STEPS = mhh_pkg::DEF_ANGLE_STEPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_data_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mhh_pkg::t_dp_cmd o_cmd
);
    import mhh_pkg::*;

    localparam int NUM_STEPS = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step  = TBL_IDX_W'(r_step);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_data_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CENTER;
                end
            end
            S_CENTER: begin
                o_cmd.center = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_WRAP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken item");
    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |=> r_out_valid)
        else $error("loaded result not presented");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LAST_STEP)
        else $error("step counter past last step");
    a_ready_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_data_ready) |=> (r_state == S_CENTER))
        else $error("ready poll not started");
`endif

endmodule

/* design/mhh_datapath.sv */
// Min/max tracking, centering, CORDIC vectoring and heading rounding.
`timescale 1ns / 1ps

module mhh_datapath #(
    parameter int HEADING_FRAC_BITS = mhh_pkg::DEF_HEADING_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mhh_pkg::t_dp_cmd                       i_cmd,
    input  logic signed [mhh_pkg::SAMPLE_W-1:0]    i_x_raw,
    input  logic signed [mhh_pkg::SAMPLE_W-1:0]    i_y_raw,
    output logic        [mhh_pkg::HEADING_W-1:0]   o_heading,
    output logic signed [mhh_pkg::CENTER_W-1:0]    o_x_center,
    output logic signed [mhh_pkg::CENTER_W-1:0]    o_y_center
);
    import mhh_pkg::*;

    localparam int SH = 16 - HEADING_FRAC_BITS;
    localparam logic [ZPOS_W-1:0] ROUND_HALF = ZPOS_W'(1) << (SH - 1);
    localparam logic [ZPOS_W-1:0] FULL_H     = ZPOS_W'(360) << HEADING_FRAC_BITS;

    logic signed [SAMPLE_W-1:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi;
    logic signed [SAMPLE_W-1:0] r_x, r_y;
    logic signed [CENTER_W-1:0] r_xc, r_yc;
    logic signed [OFFSET_W-1:0] r_a, r_b;
    logic signed [VEC_W-1:0]    r_vx, r_vy;
    logic signed [ANG_W-1:0]    r_z;
    logic                       r_zero;
    logic [ZPOS_W-1:0]          r_zpos;
    logic [HEADING_W-1:0]       r_heading;
    logic signed [CENTER_W-1:0] r_xc_out, r_yc_out;

    logic signed [CENTER_W-1:0] n_xc, n_yc;
    logic signed [VEC_W-1:0]    pre_vx, pre_vy, dx, dy;
    logic signed [ANG_W-1:0]    atan_v, z_plus;
    logic [ZPOS_W-1:0]          h_sum, h_sh, h_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo <= SAMPLE_W'(32767);
            r_x_hi <= SAMPLE_W'(-32768);
            r_y_lo <= SAMPLE_W'(32767);
            r_y_hi <= SAMPLE_W'(-32768);
        end else if (i_cmd.load) begin
            if (i_x_raw < r_x_lo) r_x_lo <= i_x_raw;
            if (i_x_raw > r_x_hi) r_x_hi <= i_x_raw;
            if (i_y_raw < r_y_lo) r_y_lo <= i_y_raw;
            if (i_y_raw > r_y_hi) r_y_hi <= i_y_raw;
        end
    end

    assign n_xc   = CENTER_W'(r_x_hi) + CENTER_W'(r_x_lo);
    assign n_yc   = CENTER_W'(r_y_hi) + CENTER_W'(r_y_lo);
    assign pre_vx = VEC_W'(r_b) <<< 8;
    assign pre_vy = VEC_W'(r_a) <<< 8;
    assign dx     = r_vy >>> i_cmd.step;
    assign dy     = r_vx >>> i_cmd.step;
    assign atan_v = ANG_W'(atan_entry(i_cmd.step));
    assign z_plus = r_z + ANG_FULL_TURN;
    assign h_sum  = r_zpos + ROUND_HALF;
    assign h_sh   = h_sum >> SH;
    assign h_wrap = (h_sh >= FULL_H) ? (h_sh - FULL_H) : h_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_x_raw;
            r_y <= i_y_raw;
        end
        if (i_cmd.center) begin
            r_xc <= n_xc;
            r_yc <= n_yc;
            r_a  <= (OFFSET_W'(r_x) <<< 1) - OFFSET_W'(n_xc);
            r_b  <= (OFFSET_W'(r_y) <<< 1) - OFFSET_W'(n_yc);
        end
        if (i_cmd.prep) begin
            r_zero <= (r_a == '0) && (r_b == '0);
            if (r_b < 0) begin
                r_vx <= -pre_vx;
                r_vy <= -pre_vy;
                r_z  <= ANG_HALF_TURN;
            end else begin
                r_vx <= pre_vx;
                r_vy <= pre_vy;
                r_z  <= '0;
            end
        end
        if (i_cmd.iter) begin
            if (r_vy > 0) begin
                r_vx <= r_vx + dx;
                r_vy <= r_vy - dy;
                r_z  <= r_z + atan_v;
            end else begin
                r_vx <= r_vx - dx;
                r_vy <= r_vy + dy;
                r_z  <= r_z - atan_v;
            end
        end
        if (i_cmd.wrap) begin
            r_zpos <= (r_z < 0) ? z_plus[ZPOS_W-1:0] : r_z[ZPOS_W-1:0];
        end
        if (i_cmd.result) begin
            r_heading <= r_zero ? '0 : h_wrap[HEADING_W-1:0];
            r_xc_out  <= r_xc;
            r_yc_out  <= r_yc;
        end
    end

    assign o_heading  = r_heading;
    assign o_x_center = r_xc_out;
    assign o_y_center = r_yc_out;

endmodule

/* design/magnetometer_heading_hard_iron_unit.sv */
// Top level of the hard-iron calibrated compass heading unit.
// A data-ready item passes the center, prep, CORDIC vectoring, wrap and result
// states; the vectoring loop takes one step per cycle. A new item is taken only
// in idle, and the result waits while the output still holds an untaken item.
// An item without data ready is dropped and gives no result.
// Reset (synchronous, active low) clears the control and sets min/max tracking
// to its empty range.
`timescale 1ns / 1ps

module magnetometer_heading_hard_iron_unit #(
    parameter int ANGLE_STEPS       = mhh_pkg::DEF_ANGLE_STEPS,
    parameter int HEADING_FRAC_BITS = mhh_pkg::DEF_HEADING_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // status_byte[7:0], x_raw[23:8], y_raw[39:24]
    input  logic [mhh_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // heading[14:0], x_center[31:15], y_center[48:32], zero[55:49]
    output logic [mhh_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import mhh_pkg::*;

    t_dp_cmd                    cmd;
    logic [HEADING_W-1:0]       heading;
    logic signed [CENTER_W-1:0] x_center, y_center;
    logic [STATUS_W-1:0]        status_byte;

    assign status_byte = i_s_axis_tdata[STATUS_W-1:0];

    mhh_ctrl #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_data_ready (status_byte[0]),
        .o_in_ready   (o_s_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_cmd        (cmd)
    );

    mhh_datapath #(
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_x_raw    (i_s_axis_tdata[STATUS_W +: SAMPLE_W]),
        .i_y_raw    (i_s_axis_tdata[STATUS_W + SAMPLE_W +: SAMPLE_W]),
        .o_heading  (heading),
        .o_x_center (x_center),
        .o_y_center (y_center)
    );

    assign o_m_axis_tdata = {
        (OUT_DATA_W - HEADING_W - 2 * CENTER_W)'(0),
        y_center,
        x_center,
        heading
    };

endmodule
